FILE: src/msr_pkg.sv
// Shared types, codes and reset constants of the motor speed ramp unit.
`timescale 1ns / 1ps

package msr_pkg;

   localparam logic [1:0] OP_COMMAND = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_ESTOP   = 2'd2;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   localparam logic [1:0] CSR_SPEED_LIMIT = 2'd0;
   localparam logic [1:0] CSR_RAMP_STEP   = 2'd1;
   localparam logic [1:0] CSR_PWM_SCALE   = 2'd2;
   localparam logic [1:0] CSR_PWM_PERIOD  = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0]  SPEED_LIMIT_RESET = 8'd100;
   localparam logic [7:0]  RAMP_STEP_RESET   = 8'd2;
   localparam logic [7:0]  PWM_SCALE_RESET   = 8'd84;
   localparam logic [15:0] PWM_PERIOD_RESET  = 16'd8399;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] direction;
      logic [7:0] speed;
   } msr_req_type;

   typedef struct packed {
      logic [15:0] compare_up;
      logic [15:0] compare_down;
   } msr_rsp_type;

   typedef struct packed {
      logic [7:0]  speed_limit;
      logic [7:0]  ramp_step;
      logic [7:0]  pwm_scale;
      logic [15:0] pwm_period;
   } msr_cfg_type;

endpackage

FILE: src/msr_cfg_regs.sv
// Configuration registers of the motor speed ramp unit.
`timescale 1ns / 1ps

module msr_cfg_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [msr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [msr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output msr_pkg::msr_cfg_type              cfg
);
   import msr_pkg::*;

   msr_cfg_type cfg_ff;
   msr_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_LIMIT: cfg_in.speed_limit = csr_wdata[7:0];
            CSR_RAMP_STEP:   cfg_in.ramp_step   = csr_wdata[7:0];
            CSR_PWM_SCALE:   cfg_in.pwm_scale   = csr_wdata[7:0];
            CSR_PWM_PERIOD:  cfg_in.pwm_period  = csr_wdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit <= SPEED_LIMIT_RESET;
         cfg_ff.ramp_step   <= RAMP_STEP_RESET;
         cfg_ff.pwm_scale   <= PWM_SCALE_RESET;
         cfg_ff.pwm_period  <= PWM_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/msr_ctrl.sv
// Motion state and next-state logic: command, ramp tick, emergency stop.
`timescale 1ns / 1ps

module msr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  msr_pkg::msr_req_type  item,
   input  msr_pkg::msr_cfg_type  cfg,
   output msr_pkg::msr_rsp_type  result
);
   import msr_pkg::*;

   logic [7:0]  present_speed_ff, present_speed_in;
   logic [7:0]  goal_speed_ff, goal_speed_in;
   logic [1:0]  active_dir_ff, active_dir_in;
   logic [1:0]  waiting_dir_ff, waiting_dir_in;
   logic [7:0]  waiting_speed_ff, waiting_speed_in;
   msr_rsp_type held_ff, held_in;

   always_comb begin
      logic [7:0]  sat_speed;
      logic [8:0]  up_sum;
      logic [7:0]  gap;
      logic [7:0]  tick_speed;
      logic [15:0] pulse;
      logic [15:0] pulse_clamped;

      present_speed_in = present_speed_ff;
      goal_speed_in    = goal_speed_ff;
      active_dir_in    = active_dir_ff;
      waiting_dir_in   = waiting_dir_ff;
      waiting_speed_in = waiting_speed_ff;
      held_in          = held_ff;

      sat_speed = (item.speed > cfg.speed_limit) ? cfg.speed_limit : item.speed;

      // Ramp one step toward the goal, never past it
      up_sum = {1'b0, present_speed_ff} + {1'b0, cfg.ramp_step};
      gap    = present_speed_ff - goal_speed_ff;
      if (present_speed_ff < goal_speed_ff) begin
         tick_speed = (up_sum > {1'b0, goal_speed_ff}) ? goal_speed_ff : up_sum[7:0];
      end else if (present_speed_ff > goal_speed_ff) begin
         tick_speed = (gap < cfg.ramp_step) ? goal_speed_ff
                                            : present_speed_ff - cfg.ramp_step;
      end else begin
         tick_speed = present_speed_ff;
      end
      pulse         = {8'd0, tick_speed} * {8'd0, cfg.pwm_scale};
      pulse_clamped = (pulse > cfg.pwm_period) ? cfg.pwm_period : pulse;

      unique case (item.opcode)
         OP_COMMAND: begin
            if (item.direction != DIR_UP && item.direction != DIR_DOWN) begin
               goal_speed_in    = 8'd0;
               waiting_dir_in   = DIR_STOP;
               waiting_speed_in = 8'd0;
            end else if (active_dir_ff != DIR_STOP && item.direction != active_dir_ff &&
                         present_speed_ff != 8'd0) begin
               // Reversal while turning: hold it and ramp down first
               waiting_dir_in   = item.direction;
               waiting_speed_in = sat_speed;
               goal_speed_in    = 8'd0;
            end else begin
               waiting_dir_in   = DIR_STOP;
               waiting_speed_in = 8'd0;
               goal_speed_in    = sat_speed;
               active_dir_in    = item.direction;
            end
         end
         OP_TICK: begin
            present_speed_in = tick_speed;
            if (tick_speed == 8'd0 && waiting_dir_ff != DIR_STOP) begin
               active_dir_in    = waiting_dir_ff;
               goal_speed_in    = waiting_speed_ff;
               waiting_dir_in   = DIR_STOP;
               waiting_speed_in = 8'd0;
            end
            if (goal_speed_in == 8'd0 && tick_speed == 8'd0 && waiting_dir_in == DIR_STOP) begin
               active_dir_in = DIR_STOP;
            end
            held_in.compare_up   = (active_dir_in == DIR_UP)   ? pulse_clamped : 16'd0;
            held_in.compare_down = (active_dir_in == DIR_DOWN) ? pulse_clamped : 16'd0;
         end
         OP_ESTOP: begin
            present_speed_in = 8'd0;
            goal_speed_in    = 8'd0;
            active_dir_in    = DIR_STOP;
            waiting_dir_in   = DIR_STOP;
            waiting_speed_in = 8'd0;
            held_in          = '0;
         end
         default: begin
            held_in = held_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_speed_ff <= 8'd0;
         goal_speed_ff    <= 8'd0;
         active_dir_ff    <= DIR_STOP;
         waiting_dir_ff   <= DIR_STOP;
         waiting_speed_ff <= 8'd0;
         held_ff          <= '0;
      end else if (fire) begin
         present_speed_ff <= present_speed_in;
         goal_speed_ff    <= goal_speed_in;
         active_dir_ff    <= active_dir_in;
         waiting_dir_ff   <= waiting_dir_in;
         waiting_speed_ff <= waiting_speed_in;
         held_ff          <= held_in;
      end
   end

   assign result = held_in;

endmodule

FILE: src/motor_speed_ramp_with_reversal_unit.sv
// Top level of the motor speed ramp unit with safe direction reversal.
`timescale 1ns / 1ps
// Path: a request accepted into the input register has its result loaded into the result
//   register and shown on rsp_; a stalled result register keeps it in the input register.
// Throughput: one request per cycle while rsp_stall does not hold the result register; the
//   motion state updates in one pass, so the speed register's dependency sets the rate.
// Reset: synchronous, active high; clears both valid flags, all motion state, and loads the
//   configuration defaults (limit 100, step 2, scale 84, period 8399).

module motor_speed_ramp_with_reversal_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  msr_pkg::msr_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output msr_pkg::msr_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [msr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [msr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import msr_pkg::*;

   msr_cfg_type cfg;
   msr_rsp_type result;

   // Input stage
   logic        req_valid_ff, req_valid_in;
   msr_req_type req_data_ff, req_data_in;

   // Result stage
   logic        rsp_valid_ff, rsp_valid_in;
   msr_rsp_type rsp_data_ff, rsp_data_in;

   logic rsp_open;
   logic fire;
   logic req_take;

   // The result register can load when empty or when its result leaves this cycle
   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   // Process the held request once the result register has room
   assign fire      = req_valid_ff && rsp_open;
   // Take a new request whenever the input register empties or is empty
   assign req_stall = req_valid_ff && !rsp_open;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
         req_data_in  = req_data;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         // Drop the delivered result
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   msr_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   msr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A processed request always lands in the result register
   a_fire_loads: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed request did not reach the result register");

   // Emergency stop drives both channels to zero
   a_estop_zero: assert property (@(posedge clock) disable iff (reset)
      (fire && req_data_ff.opcode == OP_ESTOP) |=>
         (rsp_data_ff.compare_up == 16'd0 && rsp_data_ff.compare_down == 16'd0))
      else $error("emergency stop left a compare nonzero");

   // The bridge never drives both channels at once
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.compare_up == 16'd0 || rsp_data_ff.compare_down == 16'd0))
      else $error("both H-bridge channels driven");

   // A held request is not lost while the result side is blocked
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !rsp_open) |=> req_valid_ff)
      else $error("request dropped while result stage was full");

endmodule
